/* sv/shmc_pkg.sv */
package shmc_pkg;

    // operating modes, encoded as reported on current_mode
    typedef enum logic [1:0] {
        MODE_STANDBY  = 2'd0,
        MODE_HOMING   = 2'd1,
        MODE_WAITING  = 2'd2,
        MODE_ROTATING = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [1:0] REG_HOME_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_SLEEP_LIMIT_MS  = 2'd1;
    localparam logic [1:0] REG_STEPS_PER_CYCLE = 2'd2;

    localparam int THRESHOLD_W = 10;
    localparam int LIMIT_W     = 16;
    localparam int STEPS_W     = 16;
    localparam int TIME_W      = 32;

    // register reset values
    localparam logic [THRESHOLD_W-1:0] HOME_THRESHOLD_RST  = 10'd150;
    localparam logic [LIMIT_W-1:0]     SLEEP_LIMIT_RST     = 16'd5000;
    localparam logic [STEPS_W-1:0]     STEPS_PER_CYCLE_RST = 16'd400;

    // configuration seen by the control pass
    typedef struct packed {
        logic [THRESHOLD_W-1:0] home_threshold;
        logic [LIMIT_W-1:0]     sleep_limit_ms;
        logic [STEPS_W-1:0]     steps_per_cycle;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic  home_seen;
        mode_t current_mode;
        logic  motor_enable;
        logic  step_request;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

/* sv/shmc_cfg.sv */
module shmc_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    output shmc_pkg::cfg_t     cfg
);

    shmc_pkg::cfg_t cfg_reg;

    // register file, writes past the last index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home_threshold  <= shmc_pkg::HOME_THRESHOLD_RST;
            cfg_reg.sleep_limit_ms  <= shmc_pkg::SLEEP_LIMIT_RST;
            cfg_reg.steps_per_cycle <= shmc_pkg::STEPS_PER_CYCLE_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                shmc_pkg::REG_HOME_THRESHOLD:
                    cfg_reg.home_threshold <= wr_data[shmc_pkg::THRESHOLD_W-1:0];
                shmc_pkg::REG_SLEEP_LIMIT_MS:
                    cfg_reg.sleep_limit_ms <= wr_data[shmc_pkg::LIMIT_W-1:0];
                shmc_pkg::REG_STEPS_PER_CYCLE:
                    cfg_reg.steps_per_cycle <= wr_data[shmc_pkg::STEPS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/shmc_pass.sv */
module shmc_pass
#(
    parameter int COUNT_WIDTH = 16,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  shmc_pkg::cfg_t         cfg,
    input  logic                   click,
    input  logic                   long_press,
    input  logic [SAMPLE_BITS-1:0] sensor_sample,
    input  logic [31:0]            now_ms,
    output shmc_pkg::result_t      result
);

    localparam int CMP_W = (SAMPLE_BITS > shmc_pkg::THRESHOLD_W) ?
                           SAMPLE_BITS : shmc_pkg::THRESHOLD_W;

    shmc_pkg::mode_t          mode_reg, mode_next;
    logic                     entry_reg, entry_next;
    logic [31:0]              start_reg, start_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic                     enable_reg, enable_next;

    shmc_pkg::mode_t          btn_mode;
    shmc_pkg::mode_t          pick_mode;
    logic                     home;
    logic                     expired;
    logic                     step;
    logic [31:0]              start_eff;
    logic [31:0]              elapsed;
    logic [COUNT_WIDTH-1:0]   count_inc;
    logic [COUNT_WIDTH-1:0]   steps_cut;
    logic [CMP_W-1:0]         sample_ext;
    logic [CMP_W-1:0]         thresh_ext;
    logic [63:0]              steps_wide;

    // home detect and width alignment of the compared values
    assign sample_ext = CMP_W'(sensor_sample);
    assign thresh_ext = CMP_W'(cfg.home_threshold);
    assign home       = sample_ext < thresh_ext;
    assign steps_wide = 64'(cfg.steps_per_cycle);
    assign steps_cut  = steps_wide[COUNT_WIDTH-1:0];
    assign count_inc  = count_reg + COUNT_WIDTH'(1);

    // mode start time as seen after a pending entry action
    assign start_eff = (entry_reg && (mode_reg == shmc_pkg::MODE_HOMING ||
                        mode_reg == shmc_pkg::MODE_WAITING)) ? now_ms : start_reg;
    assign elapsed   = now_ms - start_eff;
    assign expired   = elapsed > 32'(cfg.sleep_limit_ms);

    // button choice, long press wins
    always_comb
    begin
        btn_mode = mode_reg;
        if (click)
        begin
            case (mode_reg)
                shmc_pkg::MODE_STANDBY: btn_mode = shmc_pkg::MODE_HOMING;
                shmc_pkg::MODE_WAITING: btn_mode = shmc_pkg::MODE_ROTATING;
                default:                btn_mode = shmc_pkg::MODE_WAITING;
            endcase
        end
        if (long_press)
        begin
            btn_mode = shmc_pkg::MODE_HOMING;
        end
    end

    // mode body with entry actions
    always_comb
    begin
        pick_mode   = btn_mode;
        step        = 1'b0;
        start_next  = start_eff;
        count_next  = count_reg;
        enable_next = enable_reg;
        case (mode_reg)
            shmc_pkg::MODE_STANDBY:
            begin
                if (entry_reg)
                begin
                    enable_next = 1'b0;
                end
            end
            shmc_pkg::MODE_HOMING:
            begin
                if (entry_reg)
                begin
                    enable_next = 1'b1;
                end
                if (home)
                begin
                    pick_mode = shmc_pkg::MODE_WAITING;
                end
                else
                begin
                    step = 1'b1;
                end
                if (expired)
                begin
                    pick_mode = shmc_pkg::MODE_STANDBY;
                end
            end
            shmc_pkg::MODE_WAITING:
            begin
                if (entry_reg)
                begin
                    count_next = '0;
                end
                if (expired)
                begin
                    enable_next = 1'b0;
                end
            end
            shmc_pkg::MODE_ROTATING:
            begin
                if (entry_reg)
                begin
                    enable_next = 1'b1;
                end
                step = 1'b1;
                if (count_inc == steps_cut)
                begin
                    pick_mode  = shmc_pkg::MODE_WAITING;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
            end
        endcase
        mode_next  = pick_mode;
        entry_next = (pick_mode != mode_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= shmc_pkg::MODE_STANDBY;
            entry_reg  <= 1'b1;
            start_reg  <= '0;
            count_reg  <= '0;
            enable_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            entry_reg  <= entry_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            enable_reg <= enable_next;
        end
    end

    assign result.step_request = step;
    assign result.motor_enable = enable_next;
    assign result.current_mode = mode_next;
    assign result.home_seen    = home;

endmodule

/* sv/stepper_homing_mode_controller.sv */
// channel   direction  handshake              contents
// s_*       in         s_tvalid / s_tready    one control pass item
// m_*       out        m_tvalid / m_tready    one result item per pass
// cfg_*     in         cfg_valid / cfg_ready  register index and value
//
// an accepted item waits in the input register until the result register is free
// and then moves into it, and its result is offered from the result register
// a new item is taken every cycle while results are taken; the mode update is one compare chain
// and a 32-bit time subtract and compare between those two registers
// reset returns the mode state and the configuration to their reset values and clears both valid flags
// a stalled result holds the result register; the input register still
// takes one more item, then s_tready drops until the result is taken
module stepper_homing_mode_controller
#(
    parameter int COUNT_WIDTH = 16,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // click, long_press, sensor_sample, now_ms, zero fill
    input  logic [((2 + SAMPLE_BITS + shmc_pkg::TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // step_request, motor_enable, current_mode[1:0], home_seen, zero fill
    output logic [((shmc_pkg::RESULT_W + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int IN_BITS = 2 + SAMPLE_BITS + shmc_pkg::TIME_W;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W   = ((shmc_pkg::RESULT_W + 7) / 8) * 8;

    logic                    in_valid_reg;
    logic [IN_BITS-1:0]      in_data_reg;
    logic                    out_valid_reg;
    shmc_pkg::result_t       out_data_reg;
    logic                    advance;
    shmc_pkg::cfg_t          cfg;
    shmc_pkg::result_t       result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    shmc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
    end

    // one control pass on the registered item
    shmc_pass
    #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_pass
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .cfg           (cfg),
        .click         (in_data_reg[0]),
        .long_press    (in_data_reg[1]),
        .sensor_sample (in_data_reg[2 +: SAMPLE_BITS]),
        .now_ms        (in_data_reg[2 + SAMPLE_BITS +: shmc_pkg::TIME_W]),
        .result        (result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    // a pass always leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("pass did not load the result register");

    // an item waiting in the input register is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending item dropped from the input register");

    // a stalled result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("stalled result overwritten");

endmodule

/* tb/stepper_homing_mode_controller_checker.sv */
`timescale 1ns / 100ps

module stepper_homing_mode_controller_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // click, long_press, sensor_sample, now_ms, zero fill
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // step_request, motor_enable, current_mode[1:0], home_seen, zero fill
    input  logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          failures,
    output int          pending
);

    // shadow of the controller state and its registers
    shmc_pkg::mode_t   cur_mode;
    shmc_pkg::mode_t   pick_mode;
    logic              entry_due;
    logic [31:0]       mode_t0;
    logic [15:0]       cycle_steps;
    logic              enable_q;
    shmc_pkg::cfg_t    cfg_q;

    shmc_pkg::result_t expected_results[$];

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    // one control pass: button choice, mode body, then mode switch
    task automatic run_control_pass(input logic [47:0] item);
        logic              click;
        logic              long_press;
        logic              home;
        logic              step;
        logic              entering;
        logic [9:0]        sample;
        logic [31:0]       now;
        logic [31:0]       elapsed;
        shmc_pkg::result_t res;

        click      = item[0];
        long_press = item[1];
        sample     = item[11:2];
        now        = item[43:12];
        home       = sample < cfg_q.home_threshold;
        step       = 1'b0;
        entering   = entry_due;

        // button events, long press wins
        if (click)
        begin
            case (cur_mode)
                shmc_pkg::MODE_STANDBY: pick_mode = shmc_pkg::MODE_HOMING;
                shmc_pkg::MODE_WAITING: pick_mode = shmc_pkg::MODE_ROTATING;
                default:                pick_mode = shmc_pkg::MODE_WAITING;
            endcase
        end
        if (long_press)
            pick_mode = shmc_pkg::MODE_HOMING;

        entry_due = 1'b0;
        case (cur_mode)
            shmc_pkg::MODE_STANDBY:
            begin
                if (entering)
                    enable_q = 1'b0;
            end
            shmc_pkg::MODE_HOMING:
            begin
                if (entering)
                begin
                    enable_q = 1'b1;
                    mode_t0  = now;
                end
                if (home)
                    pick_mode = shmc_pkg::MODE_WAITING;
                else
                    step = 1'b1;
                // timeout beats home reached
                elapsed = now - mode_t0;
                if (elapsed > {16'd0, cfg_q.sleep_limit_ms})
                    pick_mode = shmc_pkg::MODE_STANDBY;
            end
            shmc_pkg::MODE_WAITING:
            begin
                if (entering)
                begin
                    mode_t0     = now;
                    cycle_steps = '0;
                end
                elapsed = now - mode_t0;
                if (elapsed > {16'd0, cfg_q.sleep_limit_ms})
                    enable_q = 1'b0;
            end
            default:
            begin
                if (entering)
                    enable_q = 1'b1;
                step        = 1'b1;
                cycle_steps = cycle_steps + 16'd1;
                if (cycle_steps == cfg_q.steps_per_cycle)
                begin
                    pick_mode   = shmc_pkg::MODE_WAITING;
                    cycle_steps = '0;
                end
            end
        endcase

        if (pick_mode != cur_mode)
        begin
            cur_mode  = pick_mode;
            entry_due = 1'b1;
        end

        res.step_request = step;
        res.motor_enable = enable_q;
        res.current_mode = cur_mode;
        res.home_seen    = home;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            failures++;
        end
    endtask

    // compare a result item with the oldest expectation
    task automatic check_result(input logic [7:0] data);
        shmc_pkg::result_t act;
        shmc_pkg::result_t exp;

        act = shmc_pkg::result_t'(data[shmc_pkg::RESULT_W-1:0]);
        if (expected_results.size() == 0)
        begin
            $error("result item 0x%0h arrived with nothing expected", data);
            failures++;
        end
        else
        begin
            exp = expected_results.pop_front();
            check_field("step_request", exp.step_request, act.step_request);
            check_field("motor_enable", exp.motor_enable, act.motor_enable);
            check_field("current_mode", exp.current_mode, act.current_mode);
            check_field("home_seen", exp.home_seen, act.home_seen);
        end
    endtask

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode    = shmc_pkg::MODE_STANDBY;
            pick_mode   = shmc_pkg::MODE_STANDBY;
            entry_due   = 1'b1;
            mode_t0     = '0;
            cycle_steps = '0;
            enable_q    = 1'b0;
            cfg_q.home_threshold  = shmc_pkg::HOME_THRESHOLD_RST;
            cfg_q.sleep_limit_ms  = shmc_pkg::SLEEP_LIMIT_RST;
            cfg_q.steps_per_cycle = shmc_pkg::STEPS_PER_CYCLE_RST;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    shmc_pkg::REG_HOME_THRESHOLD:
                        cfg_q.home_threshold  = cfg_data[shmc_pkg::THRESHOLD_W-1:0];
                    shmc_pkg::REG_SLEEP_LIMIT_MS:
                        cfg_q.sleep_limit_ms  = cfg_data[shmc_pkg::LIMIT_W-1:0];
                    shmc_pkg::REG_STEPS_PER_CYCLE:
                        cfg_q.steps_per_cycle = cfg_data[shmc_pkg::STEPS_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                run_control_pass(s_tdata);
            pending <= expected_results.size();
        end
    end

endmodule

/* tb/stepper_homing_mode_controller_test.sv */
`timescale 1ns / 100ps

module stepper_homing_mode_controller_test;

    localparam int IN_W        = 48;
    localparam int OUT_W       = 8;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 48;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    // click, long_press, sensor_sample, now_ms, zero fill
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // step_request, motor_enable, current_mode[1:0], home_seen, zero fill
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [31:0]      cfg_data;

    int               failures;
    int               pending;
    int               src_idle_pct;
    int               sink_idle_pct;
    int               hold_reqs;
    logic [9:0]       thr_now;
    logic [31:0]      clock_ms;

    stepper_homing_mode_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stepper_homing_mode_controller_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    // clock
    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #3000000;
        $display("stepper_homing_mode_controller verification failed");
        $finish;
    end

    // result side: random stalls plus a long hold-off on request
    initial
    begin
        int hold_done;

        hold_done = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_done)
            begin
                hold_done = hold_reqs;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // offer one item, with random gaps before it; entered at a clock edge
    task automatic send_pass(input logic click, input logic long_press,
                             input logic [9:0] sample, input logic [31:0] now);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, now, sample, long_press, click};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // let every outstanding result drain
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // valid is left high between back-to-back writes
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // one random phase under a fresh register setting
    task automatic run_phase(input logic [9:0] thr, input logic [15:0] limit,
                             input logic [15:0] steps, input int tick_max,
                             input logic [31:0] start_ms, input int src_pct,
                             input int sink_pct, input logic pressure);
        logic       click;
        logic       long_press;
        logic [9:0] sample;

        wait_drain();
        write_reg(shmc_pkg::REG_HOME_THRESHOLD, {22'd0, thr});
        write_reg(shmc_pkg::REG_SLEEP_LIMIT_MS, {16'd0, limit});
        write_reg(shmc_pkg::REG_STEPS_PER_CYCLE, {16'd0, steps});
        cfg_valid     <= 1'b0;
        thr_now       = thr;
        clock_ms      = start_ms;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;

        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (pressure && n == 50)
                hold_reqs <= hold_reqs + 1;
            click      = ($urandom_range(99) < 12);
            long_press = ($urandom_range(99) < 5);
            clock_ms   = clock_ms + $urandom_range(tick_max, 0);
            // mostly advancing time, with home reached now and then
            if ($urandom_range(99) < 6)
            begin
                sample   = 10'($urandom);
                clock_ms = $urandom;
            end
            else if (thr_now != 0 && $urandom_range(99) < 18)
                sample = 10'($urandom_range(thr_now - 1, 0));
            else
                sample = 10'($urandom_range(1023, thr_now));
            send_pass(click, long_press, sample, clock_ms);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = shmc_pkg::REG_HOME_THRESHOLD;
        cfg_data      = '0;
        hold_reqs     = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        thr_now       = shmc_pkg::HOME_THRESHOLD_RST;
        clock_ms      = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed passes under the reset register values
        send_pass(1'b0, 1'b0, 10'd1023, 32'd0);
        send_pass(1'b1, 1'b0, 10'd1023, 32'd10);
        send_pass(1'b0, 1'b0, 10'd1023, 32'd20);
        // elapsed equal to the limit is not a timeout
        send_pass(1'b0, 1'b0, 10'd1023, 32'd5020);
        // home and timeout in one pass: timeout wins
        send_pass(1'b0, 1'b0, 10'd0, 32'd5021);
        send_pass(1'b0, 1'b0, 10'd500, 32'd5030);
        send_pass(1'b0, 1'b1, 10'd500, 32'd5040);
        send_pass(1'b0, 1'b0, 10'd1023, 32'd5050);
        // just below threshold is home
        send_pass(1'b0, 1'b0, 10'd149, 32'd5060);
        send_pass(1'b0, 1'b0, 10'd150, 32'd5070);
        // idle power cut
        send_pass(1'b0, 1'b0, 10'd150, 32'd10071);
        send_pass(1'b1, 1'b0, 10'd150, 32'd10080);
        send_pass(1'b0, 1'b0, 10'd150, 32'd10090);
        send_pass(1'b0, 1'b0, 10'd150, 32'd10100);
        // leave rotating early, count kept until waiting entry
        send_pass(1'b1, 1'b0, 10'd150, 32'd10110);
        // click and long press together: homing wins
        send_pass(1'b1, 1'b1, 10'd150, 32'd10120);
        send_pass(1'b1, 1'b0, 10'd1023, 32'd10130);
        // time wraps through zero
        send_pass(1'b0, 1'b0, 10'd1023, 32'hFFFF_FFFF);
        send_pass(1'b0, 1'b0, 10'd1023, 32'd100);
        send_pass(1'b1, 1'b0, 10'd0, 32'd200);
        send_pass(1'b0, 1'b0, 10'd0, 32'd210);
        send_pass(1'b0, 1'b0, 10'd0, 32'd220);

        // random phases: register extremes, then assorted settings
        run_phase(10'd1023, 16'd65535, 16'd65535, 2000, 32'd0, 13, 71, 1'b0);
        run_phase(10'd0, 16'd0, 16'd1, 2, 32'd1000, 13, 71, 1'b0);
        run_phase(10'd512, 16'd40, 16'd6, 12, 32'd5000, 71, 13, 1'b0);
        run_phase(10'd300, 16'd200, 16'd3, 30, 32'hFFFF_F000, 71, 13, 1'b0);
        run_phase(10'd150, 16'd5000, 16'd25, 600, 32'd77, 0, 0, 1'b1);
        run_phase(10'($urandom_range(1023, 0)), 16'($urandom_range(100, 0)),
                  16'($urandom_range(10, 1)), 40, $urandom, 0, 0, 1'b0);

        wait_drain();
        if (failures == 0)
            $display("stepper_homing_mode_controller verification clean");
        else
            $display("stepper_homing_mode_controller verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/shmc_pkg.sv
sv/shmc_cfg.sv
sv/shmc_pass.sv
sv/stepper_homing_mode_controller.sv
tb/stepper_homing_mode_controller_checker.sv
tb/stepper_homing_mode_controller_test.sv
